FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/pn_pkg.sv
// Shared types and constants of the path normalizer.
`default_nettype none

package pn_pkg;

    localparam int PN_PATH_DEPTH    = 256;
    localparam int PN_SEGMENT_DEPTH = 128;
    localparam int PN_LEN_OUT_W     = 9;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_in;
        logic       last;
        logic [7:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic [7:0]              read_byte;
        logic [PN_LEN_OUT_W-1:0] path_length;
        logic                    path_valid;
        logic                    overflow;
        logic                    done_res;
    } out_word_t;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_READ   = 1'b1
    } op_kind_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_SPACE = 2'd1,
        CLS_SLASH = 2'd2,
        CLS_DOT   = 2'd3
    } char_cls_t;

    typedef struct packed {
        op_kind_t   kind;
        char_cls_t  cls;
        logic [7:0] ch;
        logic       last;
        logic [7:0] read_index;
    } op_t;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'b0001,
        PH_BODY    = 4'b0010,
        PH_ENDED   = 4'b0100,
        PH_INVALID = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_POP  = 4'b0100,
        S_EMIT = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/pn_front.sv
// Front end: accept words, classify characters, queue decoded ops.
`default_nettype none

module pn_front
    import pn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire in_word_t item,
    output logic          op_valid,
    input  wire logic     op_ready,
    output op_t           op
);

    op_t        op_in;
    op_t        q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    always_comb
    begin
        op_in.kind       = (item.cmd == CMD_READ) ? OP_READ : OP_APPEND;
        op_in.ch         = item.char_in;
        op_in.last       = item.last;
        op_in.read_index = item.read_index;
        unique case (item.char_in)
            CH_SPACE: op_in.cls = CLS_SPACE;
            CH_SLASH: op_in.cls = CLS_SLASH;
            CH_DOT:   op_in.cls = CLS_DOT;
            default:  op_in.cls = CLS_OTHER;
        endcase
    end

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready;
    assign op_valid   = (count_reg != 2'd0);
    assign pop        = op_valid && op_ready;
    assign op         = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pn_back.sv
// Back end: path state, byte store, segment stack and result register.
`default_nettype none

module pn_back
    import pn_pkg::*;
#(
    parameter int PATH_DEPTH    = PN_PATH_DEPTH,
    parameter int SEGMENT_DEPTH = PN_SEGMENT_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  op_valid,
    output logic       op_ready,
    input  wire op_t   op,
    output logic       result_valid,
    input  wire logic  result_ready,
    output out_word_t  result
);

    localparam int PA_W  = $clog2(PATH_DEPTH);
    localparam int LEN_W = $clog2(PATH_DEPTH + 1);
    localparam int SA_W  = $clog2(SEGMENT_DEPTH);
    localparam int CNT_W = $clog2(SEGMENT_DEPTH + 1);
    localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;

    typedef struct packed {
        logic             tail;
        logic [LEN_W-1:0] start;
    } seg_entry_t;

    back_state_t      state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] wl_reg, wl_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] begin_reg, begin_next;
    logic             btail_reg, btail_next;
    logic             tail_reg, tail_next;
    logic [1:0]       seg_len_reg, seg_len_next;
    logic             d0_reg, d0_next;
    logic             d1_reg, d1_next;
    logic             ovf_reg, ovf_next;
    logic             fin_reg, fin_next;
    logic [7:0]       ridx_reg, ridx_next;
    logic [7:0]       rbyte_reg, rbyte_next;
    logic             res_valid_reg, res_valid_next;
    out_word_t        res_reg, res_next;

    logic [7:0]       store_mem [PATH_DEPTH];
    logic [7:0]       store_rdata_reg;
    logic             store_we;
    logic [PA_W-1:0]  store_waddr;
    logic [7:0]       store_wdata;
    logic             store_re;
    logic [PA_W-1:0]  store_raddr;

    seg_entry_t       stack_mem [SEGMENT_DEPTH];
    seg_entry_t       stack_rdata_reg;
    logic             stack_we;
    logic [SA_W-1:0]  stack_waddr;
    seg_entry_t       stack_wdata;
    logic             stack_re;
    logic [SA_W-1:0]  stack_raddr;

    logic             do_close;
    logic             pop_req;

    assign op_ready     = (state_reg == S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign store_raddr  = PA_W'(op.read_index);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        wl_next        = wl_reg;
        cnt_next       = cnt_reg;
        begin_next     = begin_reg;
        btail_next     = btail_reg;
        tail_next      = tail_reg;
        seg_len_next   = seg_len_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        ovf_next       = ovf_reg;
        fin_next       = fin_reg;
        ridx_next      = ridx_reg;
        rbyte_next     = rbyte_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        store_we       = 1'b0;
        store_waddr    = PA_W'(wl_reg);
        store_wdata    = CH_SLASH;
        store_re       = 1'b0;
        stack_we       = 1'b0;
        stack_waddr    = SA_W'(cnt_reg);
        stack_wdata    = '{tail: btail_reg, start: begin_reg};
        stack_re       = 1'b0;
        stack_raddr    = SA_W'(cnt_reg);
        do_close       = 1'b0;
        pop_req        = 1'b0;

        // Drop the result word once taken.
        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    if (op.kind == OP_READ)
                    begin
                        store_re   = 1'b1;
                        ridx_next  = op.read_index;
                        state_next = S_READ;
                    end
                    else
                    begin
                        rbyte_next = 8'd0;
                        fin_next   = 1'b0;
                        // A new path starts after an ended one.
                        if (phase_next == PH_ENDED)
                        begin
                            wl_next    = '0;
                            cnt_next   = '0;
                            begin_next = '0;
                            ovf_next   = 1'b0;
                            phase_next = PH_LEAD;
                        end
                        unique case (phase_next)
                            PH_LEAD:
                            begin
                                if (op.cls == CLS_SPACE)
                                begin
                                    if (op.last)
                                    begin
                                        phase_next = PH_ENDED;
                                    end
                                end
                                else if (op.cls == CLS_SLASH)
                                begin
                                    store_we     = 1'b1;
                                    store_waddr  = '0;
                                    store_wdata  = CH_SLASH;
                                    wl_next      = LEN_W'(1);
                                    begin_next   = LEN_W'(1);
                                    btail_next   = 1'b1;
                                    tail_next    = 1'b1;
                                    seg_len_next = 2'd0;
                                    phase_next   = PH_BODY;
                                    fin_next     = op.last;
                                end
                                else
                                begin
                                    phase_next = op.last ? PH_ENDED : PH_INVALID;
                                end
                            end
                            PH_INVALID:
                            begin
                                if (op.last)
                                begin
                                    phase_next = PH_ENDED;
                                end
                            end
                            PH_BODY:
                            begin
                                fin_next = op.last;
                                if (op.cls != CLS_SLASH)
                                begin
                                    if (wl_next < LEN_W'(PATH_DEPTH))
                                    begin
                                        store_we    = 1'b1;
                                        store_waddr = PA_W'(wl_next);
                                        store_wdata = op.ch;
                                        wl_next     = wl_next + LEN_W'(1);
                                        tail_next   = 1'b0;
                                        if (seg_len_next == 2'd0)
                                        begin
                                            d0_next = (op.cls == CLS_DOT);
                                        end
                                        if (seg_len_next == 2'd1)
                                        begin
                                            d1_next = (op.cls == CLS_DOT);
                                        end
                                        if (seg_len_next != 2'd3)
                                        begin
                                            seg_len_next = seg_len_next + 2'd1;
                                        end
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                end
                                do_close = (op.cls == CLS_SLASH) || op.last;
                            end
                            default:
                            begin
                                phase_next = PH_LEAD;
                            end
                        endcase

                        // Close the open segment; at most one real close per word.
                        if (do_close && seg_len_next != 2'd0)
                        begin
                            if (seg_len_next == 2'd1 && d0_next)
                            begin
                                wl_next   = begin_next;
                                tail_next = btail_next;
                            end
                            else if (seg_len_next == 2'd2 && d0_next && d1_next)
                            begin
                                wl_next   = begin_next;
                                tail_next = btail_next;
                                if (cnt_next != '0)
                                begin
                                    cnt_next    = cnt_next - CNT_W'(1);
                                    stack_re    = 1'b1;
                                    stack_raddr = SA_W'(cnt_next);
                                    pop_req     = 1'b1;
                                end
                            end
                            else
                            begin
                                if (cnt_next < CNT_W'(SEGMENT_DEPTH))
                                begin
                                    stack_we    = 1'b1;
                                    stack_waddr = SA_W'(cnt_next);
                                    stack_wdata = '{tail: btail_next, start: begin_next};
                                    cnt_next    = cnt_next + CNT_W'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                                if (op.cls == CLS_SLASH)
                                begin
                                    if (wl_next < LEN_W'(PATH_DEPTH))
                                    begin
                                        store_we    = 1'b1;
                                        store_waddr = PA_W'(wl_next);
                                        store_wdata = CH_SLASH;
                                        wl_next     = wl_next + LEN_W'(1);
                                        tail_next   = 1'b1;
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                end
                            end
                            begin_next   = wl_next;
                            btail_next   = tail_next;
                            seg_len_next = 2'd0;
                        end

                        if (pop_req)
                        begin
                            state_next = S_POP;
                        end
                        else
                        begin
                            if (fin_next)
                            begin
                                if (wl_next > LEN_W'(1) && tail_next)
                                begin
                                    wl_next = wl_next - LEN_W'(1);
                                end
                                phase_next = PH_ENDED;
                            end
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_POP:
            begin
                wl_next      = stack_rdata_reg.start;
                tail_next    = stack_rdata_reg.tail;
                begin_next   = stack_rdata_reg.start;
                btail_next   = stack_rdata_reg.tail;
                seg_len_next = 2'd0;
                if (fin_reg)
                begin
                    if (wl_next > LEN_W'(1) && tail_next)
                    begin
                        wl_next = wl_next - LEN_W'(1);
                    end
                    phase_next = PH_ENDED;
                end
                state_next = S_EMIT;
            end
            S_READ:
            begin
                rbyte_next = (CMP_W'(ridx_reg) < CMP_W'(wl_reg)) ? store_rdata_reg : 8'd0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next.read_byte   = rbyte_reg;
                    res_next.path_length = PN_LEN_OUT_W'(wl_reg);
                    res_next.path_valid  = (phase_reg == PH_BODY) ||
                                           ((phase_reg == PH_ENDED) && (wl_reg != '0));
                    res_next.overflow    = ovf_reg;
                    res_next.done_res    = (phase_reg == PH_ENDED);
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_LEAD;
            wl_reg        <= '0;
            cnt_reg       <= '0;
            begin_reg     <= '0;
            btail_reg     <= 1'b0;
            tail_reg      <= 1'b0;
            seg_len_reg   <= 2'd0;
            d0_reg        <= 1'b0;
            d1_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wl_reg        <= wl_next;
            cnt_reg       <= cnt_next;
            begin_reg     <= begin_next;
            btail_reg     <= btail_next;
            tail_reg      <= tail_next;
            seg_len_reg   <= seg_len_next;
            d0_reg        <= d0_next;
            d1_reg        <= d1_next;
            ovf_reg       <= ovf_next;
            fin_reg       <= fin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg  <= ridx_next;
        rbyte_reg <= rbyte_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (store_re)
        begin
            store_rdata_reg <= store_mem[store_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re)
        begin
            stack_rdata_reg <= stack_mem[stack_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/path_normalizer.sv
// Top level of the path normalizer: front end, op queue and back end.
//
// Path normalizer. Feed a path one character per input word (cmd = append),
// with last set on its final character; leading spaces are skipped, the
// path must then start with '/', repeated slashes collapse, "." segments
// drop, ".." pops the previous segment (ignored at the root) and a trailing
// slash is removed except for the root itself. Read words (cmd = read)
// fetch the canonical byte at read_index, or 0 beyond the current length.
// Every word returns exactly one result word carrying the current length,
// path_valid, the overflow flag and done_res. The first append word after
// a finished path starts a new one. In the back end a read word, and an
// append that closes a ".." segment while the segment stack is not empty,
// pass a read or pop state before emitting, to wait on the registered read
// port of the byte store or segment stack. The back end takes no new word until
// the last result is registered. The front end classifies characters and
// holds up to two words in a queue, so the input keeps flowing while a
// result word waits on the output. The stores need no clearing after reset:
// no byte or stack entry is read before it has been written.
`default_nettype none

module path_normalizer
    import pn_pkg::*;
#(
    parameter int PATH_DEPTH    = PN_PATH_DEPTH,
    parameter int SEGMENT_DEPTH = PN_SEGMENT_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_word_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_word_t      result
);

    // Decoded op handoff between the two halves.
    logic op_valid;
    logic op_ready;
    op_t  op;

    // Front end: classify each character and queue it.
    pn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op)
    );

    // Back end: advance the path state, hold the result word until taken.
    pn_back #(
        .PATH_DEPTH    (PATH_DEPTH),
        .SEGMENT_DEPTH (SEGMENT_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: rtl/pn_checker.sv
// Port-level checker for the path normalizer, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module pn_checker
    import pn_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      result_valid,
    input wire logic      result_ready,
    input wire out_word_t result
);

    // Hold a stalled result word.
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

    // An invalid or not yet started path has no length.
    `ASSERT_IMPLY(a_invalid_empty, clk, rst_n, result_valid && !result.path_valid, result.path_length == 9'd0)

    // Overflow can only come from a path that began with a slash.
    `ASSERT_IMPLY(a_overflow_valid, clk, rst_n, result_valid && result.overflow, result.path_valid)

endmodule

bind path_normalizer pn_checker u_pn_checker (.*);

`default_nettype wire
